// ===== src/rsm_pkg.sv =====
// ---------------------------------------------------------------------------
// rsm_pkg: shared types and constants for the matrix rotator
// Register indexes, data widths, sequencer state and read control struct.
// ---------------------------------------------------------------------------
package rsm_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int SIDE_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE      = 2'd1;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd8;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic en;
        logic last;
    } rd_ctrl_t;

endpackage

// ===== src/rotate_square_matrix_90.sv =====
// ---------------------------------------------------------------------------
// rotate_square_matrix_90: square matrix rotation by 90 degrees
// Collects an n-by-n matrix and replays it turned clockwise or anticlockwise.
// ---------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_valid/cfg_ready write channel, always ready.
//   cfg_index 0 selects direction (0 clockwise, 1 anticlockwise),
//   cfg_index 1 selects the side n (0 reads as 1, above MAX_SIDE saturates).
//   Input: an element is taken at each edge with start high and busy low,
//   one per cycle, row-major. A load is n*n elements.
//   Output: the item that completes the matrix starts the readout. The
//   sequencer issues one memory read per cycle, n*n reads in all, busy high
//   meanwhile; each element appears on element_out with strobe high for one
//   cycle, the cycle after its read is issued, so the first result trails
//   the completing item by the sequencer state and read data registers,
//   with last on the final one. Readout is paced by the single read port
//   of the element memory. No element is taken while busy is high.
//   Results cannot be stalled; the receiver takes each one as it appears.
//   Reset clears the load count, the sequencer state and the output strobe and
//   returns direction to clockwise and side to 8. Memory contents are not
//   cleared; every entry is written before it is read.
// ---------------------------------------------------------------------------
module rotate_square_matrix_90 #(
    parameter int MAX_SIDE = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [rsm_pkg::DATA_W-1:0]  element,
    output logic                               strobe,
    output logic signed [rsm_pkg::DATA_W-1:0]  element_out,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rsm_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(MAX_SIDE + 1);

    logic              direction_reg, direction_next;
    logic [SIDE_W-1:0] side_reg, side_next;
    logic [AW-1:0]     count_reg, count_next;
    logic              strobe_reg;
    logic              last_reg;

    logic [SW-1:0]     n_act;
    logic [CW-1:0]     total;
    logic [CW-1:0]     count_inc;
    logic              accept;
    logic              complete;
    logic              seq_busy;
    rd_ctrl_t          rd;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    // config decode
    always_comb
    begin
        direction_next = direction_reg;
        side_next      = side_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DIRECTION: direction_next = cfg_data[0];
                REG_SIDE:      side_next      = cfg_data[SIDE_W-1:0];
                default:
                begin
                    direction_next = direction_reg;
                    side_next      = side_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (side_reg == '0)
        begin
            n_act = SW'(1);
        end
        else if (side_reg > SIDE_W'(MAX_SIDE))
        begin
            n_act = SW'(MAX_SIDE);
        end
        else
        begin
            n_act = SW'(side_reg);
        end
    end

    assign total      = CW'(CW'(n_act) * CW'(n_act));
    assign accept     = start && !seq_busy;
    assign count_inc  = CW'(count_reg) + CW'(1);
    assign complete   = (count_inc >= total);
    assign count_next = accept ? (complete ? '0 : AW'(count_inc)) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            side_reg      <= SIDE_RESET;
            count_reg     <= '0;
            strobe_reg    <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            direction_reg <= direction_next;
            side_reg      <= side_next;
            count_reg     <= count_next;
            strobe_reg    <= rd.en;
            last_reg      <= rd.en && rd.last;
        end
    end

    rsm_store #(
        .MAX_SIDE (MAX_SIDE)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (count_reg),
        .wr_data (element),
        .rd_en   (rd.en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rsm_seq #(
        .MAX_SIDE (MAX_SIDE)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .launch  (accept && complete),
        .n       (n_act),
        .dir     (direction_reg),
        .busy    (seq_busy),
        .rd      (rd),
        .rd_addr (rd_addr)
    );

    assign busy        = seq_busy;
    assign strobe      = strobe_reg;
    assign last        = last_reg;
    assign element_out = $signed(rd_data);

    a_strobe_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result strobe without readout in progress");

    a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last flag without result strobe");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("still busy on final result");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg == '0))
        else $error("load count not cleared during readout");

endmodule

// ===== src/rsm_store.sv =====
// ---------------------------------------------------------------------------
// rsm_store: element memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module rsm_store #(
    parameter int MAX_SIDE = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE > 1 ? MAX_SIDE*MAX_SIDE : 2)-1:0] wr_addr,
    input  logic [rsm_pkg::DATA_W-1:0]             wr_data,
    input  logic                                   rd_en,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE > 1 ? MAX_SIDE*MAX_SIDE : 2)-1:0] rd_addr,
    output logic [rsm_pkg::DATA_W-1:0]             rd_data
);
    import rsm_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rsm_seq.sv =====
// ---------------------------------------------------------------------------
// rsm_seq: readout sequencer
// Walks the rotated matrix in row-major order, stepping the read address
// by plus or minus n along a row and by one between row starts.
// ---------------------------------------------------------------------------
module rsm_seq #(
    parameter int MAX_SIDE = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   launch,
    input  logic [$clog2(MAX_SIDE+1)-1:0]          n,
    input  logic                                   dir,
    output logic                                   busy,
    output rsm_pkg::rd_ctrl_t                      rd,
    output logic [$clog2(MAX_SIDE*MAX_SIDE > 1 ? MAX_SIDE*MAX_SIDE : 2)-1:0] rd_addr
);
    import rsm_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int IW    = $clog2(MAX_SIDE > 1 ? MAX_SIDE : 2);

    seq_state_t      state_reg, state_next;
    logic [IW-1:0]   i_reg, i_next;
    logic [IW-1:0]   j_reg, j_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [AW-1:0]   row_reg, row_next;
    logic [AW-1:0]   n_reg, n_next;
    logic [IW-1:0]   nm1_reg, nm1_next;
    logic            dir_reg, dir_next;

    logic [AW-1:0]   n_ext;
    logic [AW-1:0]   start_addr;
    logic [AW-1:0]   row_step;
    logic            row_end;
    logic            mat_end;

    assign n_ext      = AW'(n);
    assign start_addr = dir ? (n_ext - AW'(1)) : AW'(n_ext * (n_ext - AW'(1)));
    assign row_end    = (j_reg == nm1_reg);
    assign mat_end    = row_end && (i_reg == nm1_reg);
    assign row_step   = dir_reg ? (row_reg - AW'(1)) : (row_reg + AW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (mat_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy    = 1'b0;
        rd.en   = 1'b0;
        rd.last = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_EMIT:
            begin
                busy    = 1'b1;
                rd.en   = 1'b1;
                rd.last = mat_end;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign rd_addr = addr_reg;

    // address unit
    always_comb
    begin
        i_next    = i_reg;
        j_next    = j_reg;
        addr_next = addr_reg;
        row_next  = row_reg;
        n_next    = n_reg;
        nm1_next  = nm1_reg;
        dir_next  = dir_reg;
        if (state_reg == ST_IDLE)
        begin
            if (launch)
            begin
                i_next    = '0;
                j_next    = '0;
                addr_next = start_addr;
                row_next  = start_addr;
                n_next    = n_ext;
                nm1_next  = IW'(n - SW'(1));
                dir_next  = dir;
            end
        end
        else if (row_end)
        begin
            j_next    = '0;
            i_next    = i_reg + IW'(1);
            row_next  = row_step;
            addr_next = row_step;
        end
        else
        begin
            j_next    = j_reg + IW'(1);
            addr_next = dir_reg ? (addr_reg + n_reg) : (addr_reg - n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        addr_reg <= addr_next;
        row_reg  <= row_next;
        n_reg    <= n_next;
        nm1_reg  <= nm1_next;
        dir_reg  <= dir_next;
    end

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking testbench for rotate_square_matrix_90
// Loads square matrices one element at a time and checks every rotated
// element and its last flag against an in-bench rotation predictor. A short
// table covers the extremes, side clamping, spare register indexes and
// register changes in the middle of a load. Random matrices follow, with
// random sides, directions, input gaps and broken loads.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsm_pkg::*;

    localparam int MAX_SIDE     = 8;
    localparam int STORE_DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int RANDOM_ITEMS = 420;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PRINT_CAP    = 40;
    localparam int DIR_ROWS     = 34;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } rot_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [DATA_W-1:0]     value;
        logic                  typed;
        logic [DATA_W-1:0]     want_value;
        logic                  want_last;
    } dir_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic signed [DATA_W-1:0]     element;
    logic                         strobe;
    logic signed [DATA_W-1:0]     element_out;
    logic                         last;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;

    logic [DATA_W-1:0]     matrix_mem [STORE_DEPTH];
    logic [6:0]            fill_count   = '0;
    logic                  turn_ccw     = 1'b0;
    logic [SIDE_W-1:0]     side_setting = SIDE_RESET;
    rot_result_t           rot_buf [STORE_DEPTH];
    rot_result_t           pending_rotated [$];

    bit no_gaps         = 1'b0;
    int items_sent      = 0;
    int matrices_done   = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_WRITE, REG_SIDE,      4'd1, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b1},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 1'b1},
        '{ROW_WRITE, REG_SIDE,      4'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h5a5a_5a5a, 1'b1, 32'h5a5a_5a5a, 1'b1},
        '{ROW_WRITE, REG_SIDE,      4'd2, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h1111_1111, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h2222_2222, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h3333_3333, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h4444_4444, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0010, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0020, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE, REG_DIRECTION, 4'd1, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0030, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0040, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE, REG_SPARE_LO,  4'hf, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE, REG_SPARE_HI,  4'h0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE, REG_DIRECTION, 4'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE, REG_SIDE,      4'd3, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0011, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0012, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0013, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0021, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0022, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0023, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0031, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0032, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_0033, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_00a1, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_00a2, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE, REG_SIDE,      4'd1, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ITEM,  REG_DIRECTION, 4'd0, 32'h0000_00a3, 1'b0, 32'h0000_0000, 1'b0}
    };

    rotate_square_matrix_90 #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .element     (element),
        .strobe      (strobe),
        .element_out (element_out),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int active_side();
        int n;
        n = int'(side_setting);
        if (n < 1)
            n = 1;
        if (n > MAX_SIDE)
            n = MAX_SIDE;
        return n;
    endfunction

    function automatic logic [SIDE_W-1:0] pick_side();
        int roll;
        roll = int'($urandom_range(0, 19));
        if (roll == 0)
            return 4'd0;
        if (roll == 1)
            return 4'($urandom_range(9, 15));
        if (roll == 2)
            return 4'd8;
        if (roll <= 5)
            return 4'($urandom_range(5, 7));
        return 4'($urandom_range(1, 4));
    endfunction

    function automatic logic [DATA_W-1:0] pick_element();
        if ($urandom_range(0, 7) != 0)
            return $urandom();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // append one expected result at the tail of the pending list
    task automatic queue_result(input rot_result_t res);
        pending_rotated.insert(pending_rotated.size(), res);
    endtask

    // store the element, then build the turned matrix once the load is full
    task automatic rotate_predict(input logic [DATA_W-1:0] value, output int n_out);
        int n;
        int total;
        int row;
        int col;
        int k;
        n = active_side();
        total = n * n;
        n_out = 0;
        if (int'(fill_count) < STORE_DEPTH)
            matrix_mem[fill_count[5:0]] = value;
        fill_count = fill_count + 7'd1;
        if (int'(fill_count) >= total)
        begin
            fill_count = '0;
            k = 0;
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    if (!turn_ccw)
                    begin
                        row = n - 1 - j;
                        col = i;
                    end
                    else
                    begin
                        row = j;
                        col = n - 1 - i;
                    end
                    rot_buf[k].value = matrix_mem[(row * n + col) % STORE_DEPTH];
                    rot_buf[k].last  = (k + 1 == total);
                    k++;
                end
            end
            n_out = total;
            matrices_done++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_element(input logic [DATA_W-1:0] value, input logic typed = 1'b0,
                                input logic [DATA_W-1:0] want_value = '0,
                                input logic want_last = 1'b0);
        int gap;
        int n_out;
        rot_result_t typed_res;
        gap = no_gaps ? 0 : int'($urandom_range(0, 9));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        element <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rotate_predict(value, n_out);
        if (typed)
        begin
            typed_res.value = want_value;
            typed_res.last  = want_last;
            queue_result(typed_res);
        end
        else
            for (int k = 0; k < n_out; k++)
                queue_result(rot_buf[k]);
        items_sent++;
        @(negedge clk);
    endtask

    // hold off until every pending result is out and the readout has drained
    task automatic settle_block();
        start <= 1'b0;
        while (pending_rotated.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_DIRECTION)
            turn_ccw = data[0];
        else if (idx == REG_SIDE)
            side_setting = data;
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_matrix();
        int n;
        int part;
        no_gaps = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_DIRECTION, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 9) == 0)
            write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                      4'($urandom_range(0, 15)));
        write_reg(REG_SIDE, pick_side());
        n = active_side();
        // broken load: change the registers part way through
        if (n > 1 && $urandom_range(0, 4) == 0)
        begin
            part = int'($urandom_range(1, n * n - 1));
            repeat (part) send_element(pick_element());
            write_reg(REG_SIDE, pick_side());
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_DIRECTION, 4'($urandom_range(0, 15)));
        end
        do
            send_element(pick_element());
        while (fill_count != 0);
    endtask

    always @(posedge clk)
    begin : check_results
        rot_result_t want;
        if (rst_n && strobe)
        begin
            if (pending_rotated.size() == 0)
                report_mismatch("element_out with nothing pending", element_out, '0);
            else
            begin
                want = pending_rotated.pop_front();
                results_checked++;
                if (element_out !== want.value)
                    report_mismatch("element_out", element_out, want.value);
                if (last !== want.last)
                    report_mismatch("last", {31'b0, last}, {31'b0, want.last});
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_rotated.size());
            $display("** rotate_square_matrix_90: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int random_base;
        start     = 1'b0;
        element   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_WRITE)
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            else
                send_element(directed_rows[r].value, directed_rows[r].typed,
                             directed_rows[r].want_value, directed_rows[r].want_last);
        end

        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS)
            random_matrix();

        start <= 1'b0;
        while (pending_rotated.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("sent %0d elements forming %0d rotated matrices, %0d results checked",
                 items_sent, matrices_done, results_checked);
        $display("%0d register writes across both directions and sides 0 to 15, %0d mismatches",
                 reg_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("** rotate_square_matrix_90: PASSED **");
        else
            $display("** rotate_square_matrix_90: FAILED **");
        $finish;
    end

endmodule
